### hw/rtl/lsk_pkg.sv
// Shared types, constants and helpers for the lidar sector K-th nearest block.
package lsk_pkg;

    localparam int MAX_RANK   = 8;
    localparam int ANGLE_BITS = 16;
    localparam int KEPT_W     = $clog2(MAX_RANK + 1);
    localparam int IDX_W      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int CFG_AW     = 3;

    localparam logic [15:0] NEAR_RST  = 16'd180;
    localparam logic [15:0] FAR_RST   = 16'd65535;
    localparam logic [15:0] START_RST = 16'd0;
    localparam logic [15:0] STEP_RST  = 16'd182;
    localparam logic [15:0] CENTR_RST = 16'd0;
    localparam logic [15:0] HALF_RST  = 16'd5476;
    localparam logic [3:0]  RANK_RST  = 4'd3;

    typedef enum logic [CFG_AW-1:0] {
        REG_NEAR  = 3'd0,
        REG_FAR   = 3'd1,
        REG_START = 3'd2,
        REG_STEP  = 3'd3,
        REG_CENTR = 3'd4,
        REG_HALF  = 3'd5,
        REG_RANK  = 3'd6
    } t_reg_idx;

    typedef logic [ANGLE_BITS-1:0] t_angle;

    typedef struct packed {
        logic [15:0] near_limit;
        logic [15:0] far_limit;
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] sector_center;
        logic [15:0] half_width;
        logic [3:0]  confirm_count;
    } t_cfg;

    typedef struct packed {
        logic [15:0] rng;
        logic        finite;
        logic        last;
        t_angle      offset;
    } t_beam;

    typedef struct packed {
        logic [15:0] rng;
        t_angle      offset;
    } t_entry;

    typedef struct packed {
        logic        found;
        logic [15:0] rng;
        logic [15:0] offset;
    } t_result;

    function automatic t_angle ang_from_reg(input logic [15:0] v);
        logic signed [31:0] t;
        t = 32'(signed'(v));
        return t[ANGLE_BITS-1:0];
    endfunction

    function automatic logic [15:0] off_low16(input t_angle a);
        logic [31:0] t;
        t = 32'(a);
        return t[15:0];
    endfunction

endpackage

### hw/rtl/lidar_sector_kth_nearest.sv
// Top level: K-th nearest lidar return inside a sector, streamed per scan.
//
//  channel  | dir | payload (low bit up)                      | accepted when
//  s_axis   | in  | tdata: beam_range[15:0]; tuser: finite;    | tvalid & tready
//           |     | tlast: scan_end                            |
//  m_axis   | out | tdata: range[15:0], offset[31:16];         | tvalid & tready
//           |     | tuser: found                               |
//  cfg      | in  | addr: register index; data: value          | wr_en
//
//  One beam per cycle but for the stall below; a result passes the input and result registers.
//  Latency is set by the input register and the result register around the sorter.
//  Reset restores register defaults and empties the list; no clearing pass.
//  A held result stalls only a request marked last; other beams pass freely.
module lidar_sector_kth_nearest (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [15:0]                i_s_axis_tdata,  // beam_range
    input  logic                       i_s_axis_tuser,  // beam_finite
    input  logic                       i_s_axis_tlast,  // scan_end
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [31:0]                o_m_axis_tdata,  // obstacle_range, obstacle_offset
    output logic                       o_m_axis_tuser,  // found
    input  logic                       i_cfg_wr_en,
    input  logic [lsk_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]                i_cfg_data
);
    import lsk_pkg::*;

    t_cfg    r_cfg;
    t_beam   s1_beam;
    logic    s1_valid;
    logic    s1_go;
    logic    in_acc;
    logic    start_wr;
    t_result res;
    t_result r_out;
    logic    r_out_valid;

    assign s1_go           = s1_valid && (!s1_beam.last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !s1_valid || s1_go;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign start_wr        = i_cfg_wr_en && (t_reg_idx'(i_cfg_addr) == REG_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit    <= NEAR_RST;
            r_cfg.far_limit     <= FAR_RST;
            r_cfg.angle_start   <= START_RST;
            r_cfg.angle_step    <= STEP_RST;
            r_cfg.sector_center <= CENTR_RST;
            r_cfg.half_width    <= HALF_RST;
            r_cfg.confirm_count <= RANK_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_NEAR:  r_cfg.near_limit    <= i_cfg_data;
                REG_FAR:   r_cfg.far_limit     <= i_cfg_data;
                REG_START: r_cfg.angle_start   <= i_cfg_data;
                REG_STEP:  r_cfg.angle_step    <= i_cfg_data;
                REG_CENTR: r_cfg.sector_center <= i_cfg_data;
                REG_HALF:  r_cfg.half_width    <= i_cfg_data;
                REG_RANK:  r_cfg.confirm_count <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    lsk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_go          (s1_go),
        .i_range       (i_s_axis_tdata),
        .i_finite      (i_s_axis_tuser),
        .i_last        (i_s_axis_tlast),
        .i_cfg         (r_cfg),
        .i_start_wr    (start_wr),
        .i_start_value (i_cfg_data),
        .o_beam        (s1_beam),
        .o_valid       (s1_valid)
    );

    lsk_sorter u_sorter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (s1_go),
        .i_beam   (s1_beam),
        .i_cfg    (r_cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_beam.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_beam.last) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.offset, r_out.rng};
    assign o_m_axis_tuser  = r_out.found;

endmodule

### hw/rtl/lsk_front.sv
// Input register with running beam angle and sector offset.
module lsk_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_go,
    input  logic [15:0]     i_range,
    input  logic            i_finite,
    input  logic            i_last,
    input  lsk_pkg::t_cfg   i_cfg,
    input  logic            i_start_wr,
    input  logic [15:0]     i_start_value,
    output lsk_pkg::t_beam  o_beam,
    output logic            o_valid
);
    import lsk_pkg::*;

    t_angle r_angle, n_angle;
    logic   r_mid, n_mid;
    logic   r_valid, n_valid;
    t_beam  r_beam;

    always_comb begin
        n_angle = r_angle;
        n_mid   = r_mid;
        if (i_accept) begin
            if (i_last) begin
                n_angle = ang_from_reg(i_cfg.angle_start);
                n_mid   = 1'b0;
            end else begin
                n_angle = r_angle + ang_from_reg(i_cfg.angle_step);
                n_mid   = 1'b1;
            end
        end else if (i_start_wr && !r_mid) begin
            n_angle = ang_from_reg(i_start_value);
        end
        n_valid = i_accept ? 1'b1 : (i_go ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= ang_from_reg(START_RST);
            r_mid   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_angle <= n_angle;
            r_mid   <= n_mid;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_beam.rng    <= i_range;
            r_beam.finite <= i_finite;
            r_beam.last   <= i_last;
            r_beam.offset <= r_angle - ang_from_reg(i_cfg.sector_center);
        end
    end

    assign o_beam  = r_beam;
    assign o_valid = r_valid;

endmodule

### hw/rtl/lsk_sorter.sv
// Beam filter, compare-and-shift nearest list and K-th entry select.
module lsk_sorter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  lsk_pkg::t_beam   i_beam,
    input  lsk_pkg::t_cfg    i_cfg,
    output lsk_pkg::t_result o_result
);
    import lsk_pkg::*;

    t_entry              r_list [MAX_RANK];
    t_entry              n_list [MAX_RANK];
    t_entry              prev   [MAX_RANK];
    logic [MAX_RANK-1:0] le;
    logic [MAX_RANK-1:0] prev_le;
    logic [KEPT_W-1:0]   r_kept, n_kept;
    t_entry              new_ent;
    t_entry              sel;
    t_angle              mag;
    logic                keep_ok;
    logic                ins;
    int                  kc;
    logic [IDX_W-1:0]    kidx;

    always_comb begin
        mag     = i_beam.offset[ANGLE_BITS-1] ? (t_angle'(0) - i_beam.offset) : i_beam.offset;
        keep_ok = i_beam.finite
               && (i_beam.rng >= i_cfg.near_limit)
               && (i_beam.rng <= i_cfg.far_limit)
               && (32'(mag) <= 32'(i_cfg.half_width));
        new_ent.rng    = i_beam.rng;
        new_ent.offset = i_beam.offset;

        for (int i = 0; i < MAX_RANK; i++) begin
            le[i] = (KEPT_W'(i) < r_kept) && (r_list[i].rng <= i_beam.rng);
        end
        prev[0]    = new_ent;
        prev_le[0] = 1'b1;
        for (int i = 1; i < MAX_RANK; i++) begin
            prev[i]    = r_list[i-1];
            prev_le[i] = le[i-1];
        end

        ins = i_go && keep_ok && !le[MAX_RANK-1];
        for (int i = 0; i < MAX_RANK; i++) begin
            if (ins && !le[i]) begin
                n_list[i] = prev_le[i] ? new_ent : prev[i];
            end else begin
                n_list[i] = r_list[i];
            end
        end
        n_kept = (ins && (r_kept != KEPT_W'(MAX_RANK))) ? r_kept + 1'b1 : r_kept;

        if (i_cfg.confirm_count == 4'd0) begin
            kc = 1;
        end else if (int'(i_cfg.confirm_count) > MAX_RANK) begin
            kc = MAX_RANK;
        end else begin
            kc = int'(i_cfg.confirm_count);
        end
        kidx = IDX_W'(kc - 1);
        sel  = n_list[kidx];

        o_result.found = (int'(n_kept) >= kc);
        if (o_result.found) begin
            o_result.rng    = sel.rng;
            o_result.offset = off_low16(sel.offset);
        end else begin
            o_result.rng    = 16'd0;
            o_result.offset = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
        end else if (i_go && i_beam.last) begin
            r_kept <= '0;
        end else begin
            r_kept <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_list <= n_list;
        end
    end

    a_kept_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= KEPT_W'(MAX_RANK))
        else $error("kept count above list capacity");

    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_beam.last) |=> (r_kept == '0))
        else $error("list not cleared after last beam");

    a_kept_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ins && !i_beam.last && (r_kept != KEPT_W'(MAX_RANK)))
        |=> (r_kept == $past(r_kept) + 1'b1))
        else $error("kept count did not advance on insert");

endmodule

### verif/lsk_report_checker.sv
// Checker: predicts the K-th nearest sector report per scan and compares the result stream.
`timescale 1ns / 1ps

module lsk_report_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    input  logic                       i_s_axis_tready,
    input  logic [15:0]                i_s_axis_tdata,  // beam_range
    input  logic                       i_s_axis_tuser,  // beam_finite
    input  logic                       i_s_axis_tlast,  // scan_end
    input  logic                       i_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic [31:0]                i_m_axis_tdata,  // obstacle_range, obstacle_offset
    input  logic                       i_m_axis_tuser,  // found
    input  logic                       i_cfg_wr_en,
    input  logic [lsk_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]                i_cfg_data,
    output int                         o_fail_count,
    output int                         o_outstanding,
    output int                         o_reports,
    output int                         o_found
);
    import lsk_pkg::*;

    logic [15:0] near_lim, far_lim, start_ang, step_ang, centre_ang, half_ang;
    logic [3:0]  rank_sel;

    logic [15:0] beam_ang;
    logic        in_scan;
    int          kept;
    logic [15:0] near_rng [MAX_RANK];
    logic [15:0] near_off [MAX_RANK];

    t_result     pending_reports [$];
    int          fails;
    int          reports;
    int          found_cnt;

    task automatic restart_scan();
        kept = 0;
        for (int i = 0; i < MAX_RANK; i++) begin
            near_rng[i] = '0;
            near_off[i] = '0;
        end
        beam_ang = start_ang;
        in_scan  = 1'b0;
    endtask

    task automatic keep_nearest(input logic [15:0] rng, input logic [15:0] off);
        int pos;
        int i;
        pos = 0;
        while (pos < kept && near_rng[pos] <= rng) pos++;
        if (pos >= MAX_RANK) return;
        i = (kept < MAX_RANK) ? kept : MAX_RANK - 1;
        while (i > pos) begin
            near_rng[i] = near_rng[i-1];
            near_off[i] = near_off[i-1];
            i--;
        end
        near_rng[pos] = rng;
        near_off[pos] = off;
        if (kept < MAX_RANK) kept++;
    endtask

    task automatic take_beam(input logic [15:0] rng, input logic fin, input logic lst);
        logic [15:0] off;
        logic [15:0] mag;
        int          k;
        t_result     rep;
        off = beam_ang - centre_ang;
        mag = off[15] ? 16'(16'd0 - off) : off;
        if (fin && rng >= near_lim && rng <= far_lim && mag <= half_ang)
            keep_nearest(rng, off);
        in_scan  = 1'b1;
        beam_ang = beam_ang + step_ang;
        if (lst) begin
            k = int'(rank_sel);
            if (k < 1) k = 1;
            if (k > MAX_RANK) k = MAX_RANK;
            if (kept >= k) begin
                rep.found  = 1'b1;
                rep.rng    = near_rng[k-1];
                rep.offset = near_off[k-1];
            end else begin
                rep = '0;
            end
            pending_reports.push_back(rep);
            restart_scan();
        end
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [15:0] v);
        case (t_reg_idx'(idx))
            REG_NEAR: begin
                near_lim = v;
            end
            REG_FAR: begin
                far_lim = v;
            end
            REG_START: begin
                start_ang = v;
                if (!in_scan) beam_ang = v;
            end
            REG_STEP: begin
                step_ang = v;
            end
            REG_CENTR: begin
                centre_ang = v;
            end
            REG_HALF: begin
                half_ang = v;
            end
            REG_RANK: begin
                rank_sel = v[3:0];
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        fails     = 0;
        reports   = 0;
        found_cnt = 0;
    end

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            near_lim   = NEAR_RST;
            far_lim    = FAR_RST;
            start_ang  = START_RST;
            step_ang   = STEP_RST;
            centre_ang = CENTR_RST;
            half_ang   = HALF_RST;
            rank_sel   = RANK_RST;
            restart_scan();
            pending_reports.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.found  = i_m_axis_tuser;
                got.rng    = i_m_axis_tdata[15:0];
                got.offset = i_m_axis_tdata[31:16];
                reports++;
                if (got.found) found_cnt++;
                if (pending_reports.size() == 0) begin
                    $error("unexpected report: found %0d range %0d offset %0d",
                           got.found, got.rng, $signed(got.offset));
                    fails++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        fails++;
                    end
                    if (got.rng !== want.rng) begin
                        $error("obstacle_range: expected %0d, actual %0d", want.rng, got.rng);
                        fails++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("obstacle_offset: expected %0d, actual %0d",
                               $signed(want.offset), $signed(got.offset));
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en) write_reg(i_cfg_addr, i_cfg_data);
            if (i_s_axis_tvalid && i_s_axis_tready)
                take_beam(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_reports.size();
        o_reports     <= reports;
        o_found       <= found_cnt;
    end

endmodule

### verif/lidar_sector_kth_nearest_tb.sv
// Testbench top: drives beams, register writes and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module lidar_sector_kth_nearest_tb;
    import lsk_pkg::*;

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              s_valid         = 1'b0;
    logic [15:0]       s_data          = '0;
    logic              s_user          = 1'b0;
    logic              s_last          = 1'b0;
    logic              m_ready         = 1'b0;
    logic              cfg_wr_en       = 1'b0;
    logic [CFG_AW-1:0] cfg_addr        = '0;
    logic [15:0]       cfg_data        = '0;

    logic              s_ready;
    logic              m_valid;
    logic [31:0]       m_data;
    logic              m_user;

    int                fail_count;
    int                outstanding;
    int                report_count;
    int                found_count;

    int                beams_sent      = 0;
    int                scans_sent      = 0;
    bit                idle_on         = 1'b1;
    int                hold_req        = 0;
    logic [15:0]       cur_near        = NEAR_RST;
    logic [15:0]       cur_far         = FAR_RST;

    lidar_sector_kth_nearest dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    lsk_report_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_reports       (report_count),
        .o_found         (found_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("lidar_sector_kth_nearest regression: fail");
        $finish;
    end

    // back-pressure on the result side; a long hold is counted here
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= !(idle_on && $urandom_range(0, 99) < 9);
            end
        end
    end

    task automatic send_beam(input logic [15:0] rng, input logic fin, input logic lst);
        while (idle_on && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= rng;
        s_user  <= fin;
        s_last  <= lst;
        do @(posedge i_clk); while (!s_ready);
        beams_sent++;
        if (lst) scans_sent++;
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_NEAR) cur_near = v;
        if (idx == REG_FAR) cur_far = v;
    endtask

    // drain all reports, then allow the pipeline to empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return cur_near;
            3: return cur_far;
            4, 5, 6: return 16'($urandom_range(0, 30) * 100);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_setup();
        logic [15:0] v;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0: v = 16'd0;
                1: v = 16'hFFFF;
                default: v = 16'($urandom_range(0, 2000));
            endcase
            cfg_write(REG_NEAR, v);
        end
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0: v = 16'd0;
                1: v = 16'hFFFF;
                2: v = 16'($urandom_range(0, 65535));
                default: v = 16'($urandom_range(2000, 65535));
            endcase
            cfg_write(REG_FAR, v);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                default: v = 16'($urandom_range(0, 65535));
            endcase
            cfg_write(REG_START, v);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                2: v = 16'd0;
                3: v = 16'($urandom_range(0, 65535));
                default: v = 16'($urandom_range(0, 1200)) - 16'd600;
            endcase
            cfg_write(REG_STEP, v);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 16'h8000;
                1: v = 16'h7FFF;
                default: v = 16'($urandom_range(0, 65535));
            endcase
            cfg_write(REG_CENTR, v);
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0: v = 16'd0;
                1: v = 16'h8000;
                2: v = 16'($urandom_range(0, 32768));
                default: v = 16'($urandom_range(4000, 20000));
            endcase
            cfg_write(REG_HALF, v);
        end
        if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 4) == 0)
                v = 16'($urandom_range(0, 15));
            else
                v = 16'($urandom_range(1, 8));
            cfg_write(REG_RANK, v);
        end
    endtask

    initial begin : stimulus
        int rand_beams;
        int n_scans;
        int len;
        bit broken;
        bit lst;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: limits, non-finite, ties
        send_beam(16'hFFFF, 1'b1, 1'b0);
        send_beam(16'd0,    1'b1, 1'b0);
        send_beam(16'd180,  1'b1, 1'b0);
        send_beam(16'd500,  1'b0, 1'b0);
        send_beam(16'd1000, 1'b1, 1'b0);
        send_beam(16'd1000, 1'b1, 1'b0);
        send_beam(16'd300,  1'b1, 1'b1);
        settle();

        // rank zero, half-turn offsets, full sector
        cfg_write(REG_RANK, 16'd0);
        cfg_write(REG_NEAR, 16'd0);
        cfg_write(REG_HALF, 16'h8000);
        cfg_write(REG_STEP, 16'h8000);
        cfg_write(REG_CENTR, 16'h8000);
        cfg_write(REG_START, 16'h7FFF);
        send_beam(16'd0,    1'b1, 1'b0);
        send_beam(16'hFFFF, 1'b1, 1'b1);
        settle();

        // rank above capacity, full list
        cfg_write(REG_RANK, 16'd15);
        cfg_write(REG_STEP, 16'd1);
        send_beam(16'd900, 1'b1, 1'b0);
        send_beam(16'd500, 1'b1, 1'b0);
        send_beam(16'd400, 1'b1, 1'b0);
        send_beam(16'd400, 1'b1, 1'b0);
        send_beam(16'd300, 1'b1, 1'b0);
        send_beam(16'd200, 1'b1, 1'b0);
        send_beam(16'd100, 1'b1, 1'b0);
        send_beam(16'd50,  1'b1, 1'b0);
        send_beam(16'd700, 1'b1, 1'b0);
        send_beam(16'd9999, 1'b1, 1'b1);
        settle();

        // empty window
        cfg_write(REG_NEAR, 16'd1000);
        cfg_write(REG_FAR, 16'd999);
        send_beam(16'd1000, 1'b1, 1'b1);
        settle();

        // start angle written mid-scan and between scans
        cfg_write(REG_NEAR, 16'd180);
        cfg_write(REG_FAR, 16'hFFFF);
        cfg_write(REG_HALF, 16'd0);
        cfg_write(REG_CENTR, 16'h0100);
        cfg_write(REG_RANK, 16'd1);
        cfg_write(REG_START, 16'h00FE);
        send_beam(16'd200, 1'b1, 1'b0);
        settle();
        cfg_write(REG_START, 16'h0000);
        send_beam(16'd300, 1'b1, 1'b0);
        send_beam(16'd400, 1'b1, 1'b1);
        settle();
        cfg_write(REG_START, 16'h0100);
        send_beam(16'd250, 1'b1, 1'b1);
        settle();

        // hold the result side so the block fills and stalls its input
        cfg_write(REG_HALF, 16'h8000);
        hold_req++;
        for (int i = 0; i < 40; i++)
            send_beam(pick_range(), 1'b1, i[0]);
        settle();

        rand_beams = 0;
        while (rand_beams < 500) begin
            idle_on = !(rand_beams >= 150 && rand_beams < 300);
            random_setup();
            n_scans = $urandom_range(1, 5);
            broken  = ($urandom_range(0, 7) == 0);
            for (int s = 0; s < n_scans; s++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    lst = (j == len - 1) && !(broken && s == n_scans - 1);
                    send_beam(pick_range(), $urandom_range(0, 9) != 0, lst);
                    rand_beams++;
                end
            end
            settle();
        end

        s_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (10) @(posedge i_clk);

        $display("covered %0d beams over %0d scans with varied limits, sectors and ranks",
                 beams_sent, scans_sent);
        $display("%0d reports checked, %0d with a return found", report_count, found_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("lidar_sector_kth_nearest regression: pass");
        end else begin
            $display("lidar_sector_kth_nearest regression: fail");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/lsk_pkg.sv
hw/rtl/lsk_front.sv
hw/rtl/lsk_sorter.sv
hw/rtl/lidar_sector_kth_nearest.sv
verif/lsk_report_checker.sv
verif/lidar_sector_kth_nearest_tb.sv
